@@ design/ntm_pkg.sv @@
// Package for the nearest timestamp matcher: widths, status codes and the
// command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package ntm_pkg;

   // Table size and the widths that follow from it.
   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Fixed field widths.
   localparam int TIME_W = 52;
   localparam int DIFF_W = 32;
   localparam int MIDX_W = 10;
   localparam int STAT_W = 2;

   localparam logic [CNT_W-1:0]  DEPTH_CNT      = CNT_W'(TABLE_DEPTH);
   localparam logic [DIFF_W-1:0] MAX_DIFF_RESET = DIFF_W'(20000);

   // Request kinds.
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_LOADED  = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STAT_W-1:0] ST_MATCH   = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;       // request transfer: latch time, arm the scan
      logic scan;          // step the table scan
      logic load_finish;   // append entry and form the load result
      logic query_finish;  // form the query result
   } ntm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic drained;       // all entries read and compared
   } ntm_stat_type;

   // Table index to the result's index field, masked or zero extended.
   function automatic logic [MIDX_W-1:0] to_match_index(input logic [IDX_W-1:0] idx);
      logic [IDX_W+MIDX_W-1:0] wide;
      wide = {{MIDX_W{1'b0}}, idx};
      return wide[MIDX_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ design/ntm_ctrl.sv @@
// Controller of the nearest timestamp matcher: sequences loads and scans.
// Depends on ntm_pkg.
`default_nettype none

module ntm_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 req_type,
   output logic                      busy,
   output logic                      rsp_strobe,
   output ntm_pkg::ntm_cmd_type      cmd,
   input  wire ntm_pkg::ntm_stat_type stat
);
   import ntm_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOAD,
      S_SCAN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_strobe_ff, rsp_strobe_in;
   logic      accept;

   // A request is transferred only while idle.
   assign accept = start && (state_ff == S_IDLE);

   // Next state and commands.
   always_comb begin
      state_in         = state_ff;
      rsp_strobe_in    = 1'b0;
      cmd              = '0;
      cmd.capture      = accept;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req_type == REQ_QUERY) ? S_SCAN : S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load_finish = 1'b1;
            rsp_strobe_in   = 1'b1;
            state_in        = S_IDLE;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.drained) begin
               cmd.query_finish = 1'b1;
               rsp_strobe_in    = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;

   // Result strobes never come back to back.
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result strobes in consecutive cycles");

   // A query only finishes once the scan pipeline has emptied.
   a_finish_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) && !stat.drained |=> !rsp_strobe_ff)
      else $error("query result before scan drained");

endmodule

`default_nettype wire

@@ design/ntm_datapath.sv @@
// Datapath of the nearest timestamp matcher: reference table memory, entry
// count, tolerance register, scan pipeline and result registers. Uses ntm_pkg.
`default_nettype none

module ntm_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ntm_pkg::ntm_cmd_type         cmd,
   output ntm_pkg::ntm_stat_type             stat,
   input  wire logic [ntm_pkg::TIME_W-1:0]   req_time_value,
   input  wire logic                         csr_we,
   input  wire logic [ntm_pkg::DIFF_W-1:0]   csr_wdata,
   output logic [ntm_pkg::STAT_W-1:0]        rsp_status,
   output logic [ntm_pkg::TIME_W-1:0]        rsp_query_time,
   output logic [ntm_pkg::MIDX_W-1:0]        rsp_match_index,
   output logic [ntm_pkg::TIME_W-1:0]        rsp_match_time
);
   import ntm_pkg::*;

   logic [TIME_W-1:0] table_mem [TABLE_DEPTH];

   logic [DIFF_W-1:0] max_diff_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [TIME_W-1:0] time_ff;
   logic [CNT_W-1:0]  rd_addr_ff;

   logic              rd_vld_ff;
   logic [TIME_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]  rd_idx_ff;

   logic              diff_vld_ff;
   logic [TIME_W-1:0] diff_ff;
   logic [TIME_W-1:0] diff_time_ff;
   logic [IDX_W-1:0]  diff_idx_ff;

   logic              found_ff;
   logic [DIFF_W-1:0] best_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [TIME_W-1:0] best_time_ff;

   logic [STAT_W-1:0] rsp_status_ff;
   logic [TIME_W-1:0] rsp_query_time_ff;
   logic [MIDX_W-1:0] rsp_match_index_ff;
   logic [TIME_W-1:0] rsp_match_time_ff;

   logic              rd_en;
   logic              full;
   logic [TIME_W:0]   gap_fwd;
   logic [TIME_W:0]   gap_rev;
   logic [TIME_W-1:0] gap;
   logic              closer;

   assign full  = (count_ff >= DEPTH_CNT);
   assign rd_en = cmd.scan && (rd_addr_ff < count_ff);

   // Tolerance register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_diff_ff <= MAX_DIFF_RESET;
      end else if (csr_we) begin
         max_diff_ff <= csr_wdata;
      end
   end

   // Entry count grows on each load that fits.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.load_finish && !full) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   // Table memory: one write port for loads, one registered read for the scan.
   always_ff @(posedge clock) begin
      if (cmd.load_finish && !full) begin
         table_mem[count_ff[IDX_W-1:0]] <= time_ff;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr_ff[IDX_W-1:0]];
      end
   end

   // Request time and scan address.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         time_ff <= req_time_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_addr_ff <= '0;
      end else if (cmd.capture) begin
         rd_addr_ff <= '0;
      end else if (rd_en) begin
         rd_addr_ff <= rd_addr_ff + CNT_W'(1);
      end
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         diff_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= rd_en;
         diff_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_idx_ff <= rd_addr_ff[IDX_W-1:0];
      end
   end

   // Absolute gap: both differences at once, the borrow picks one.
   assign gap_fwd = {1'b0, time_ff} - {1'b0, rd_data_ff};
   assign gap_rev = {1'b0, rd_data_ff} - {1'b0, time_ff};
   assign gap     = gap_fwd[TIME_W] ? gap_rev[TIME_W-1:0] : gap_fwd[TIME_W-1:0];

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         diff_ff      <= gap;
         diff_time_ff <= rd_data_ff;
         diff_idx_ff  <= rd_idx_ff;
      end
   end

   // Keep the closest entry; a strict compare lets the lowest index win ties.
   assign closer = diff_ff < {{(TIME_W-DIFF_W){1'b0}}, best_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.capture) begin
         found_ff <= 1'b0;
      end else if (diff_vld_ff && closer) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         best_ff <= max_diff_ff;
      end else if (diff_vld_ff && closer) begin
         best_ff      <= diff_ff[DIFF_W-1:0];
         best_idx_ff  <= diff_idx_ff;
         best_time_ff <= diff_time_ff;
      end
   end

   assign stat.drained = !(rd_addr_ff < count_ff) && !rd_vld_ff && !diff_vld_ff;

   // Result registers.
   always_ff @(posedge clock) begin
      if (cmd.load_finish) begin
         rsp_query_time_ff <= time_ff;
         rsp_match_time_ff <= '0;
         if (full) begin
            rsp_status_ff      <= ST_FULL;
            rsp_match_index_ff <= '0;
         end else begin
            rsp_status_ff      <= ST_LOADED;
            rsp_match_index_ff <= to_match_index(count_ff[IDX_W-1:0]);
         end
      end else if (cmd.query_finish) begin
         rsp_query_time_ff <= time_ff;
         if (found_ff) begin
            rsp_status_ff      <= ST_MATCH;
            rsp_match_index_ff <= to_match_index(best_idx_ff);
            rsp_match_time_ff  <= best_time_ff;
         end else begin
            rsp_status_ff      <= ST_NOMATCH;
            rsp_match_index_ff <= '0;
            rsp_match_time_ff  <= '0;
         end
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_query_time  = rsp_query_time_ff;
   assign rsp_match_index = rsp_match_index_ff;
   assign rsp_match_time  = rsp_match_time_ff;

   // The entry count saturates at the table depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count beyond table depth");

   // Every read is followed by its gap stage.
   a_pipe_flow: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |=> diff_vld_ff)
      else $error("scan pipeline lost a read");

   // A recorded best match always points at a stored entry.
   a_best_stored: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> ({{(CNT_W-IDX_W){1'b0}}, best_idx_ff} < count_ff))
      else $error("best match beyond stored entries");

endmodule

`default_nettype wire

@@ design/nearest_timestamp_matcher.sv @@
// Top level of the nearest timestamp matcher: joins controller and datapath.
// Depends on ntm_pkg, ntm_ctrl and ntm_datapath.
//
// Usage. A request is transferred at a rising edge with start high and busy
// low. req_type selects a load (append req_time_value to the table) or a
// query (find the stored entry closest to req_time_value, strictly within
// the tolerance held in the csr register; on ties the lowest index wins).
// The tolerance is written with csr_we and csr_wdata while the block is idle.
// Each request gives one result, shown for exactly one cycle with rsp_strobe
// high; the receiver cannot stall it and takes it at the end of that cycle.
// A query over N stored entries reads one table memory entry per cycle,
// then passes each through a gap stage and a compare stage; on an empty
// table it reads nothing. One request is handled at a time, and busy is low
// again in the cycle of the strobe, so a new request may be transferred then.
// Reset clears the entry count and sets the tolerance to 20000 microseconds;
// the table needs no clearing pass, as only stored entries are ever read.
`default_nettype none

module nearest_timestamp_matcher (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_type,
   input  wire logic [ntm_pkg::TIME_W-1:0]  req_time_value,
   output logic                             rsp_strobe,
   output logic [ntm_pkg::STAT_W-1:0]       rsp_status,
   output logic [ntm_pkg::TIME_W-1:0]       rsp_query_time,
   output logic [ntm_pkg::MIDX_W-1:0]       rsp_match_index,
   output logic [ntm_pkg::TIME_W-1:0]       rsp_match_time,
   input  wire logic                        csr_we,
   input  wire logic [ntm_pkg::DIFF_W-1:0]  csr_wdata
);
   import ntm_pkg::*;

   ntm_cmd_type  cmd;
   ntm_stat_type stat;

   // Sequencing of loads and scans.
   ntm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_type   (req_type),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   // Table, scan pipeline and result registers.
   ntm_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_time_value  (req_time_value),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_status      (rsp_status),
      .rsp_query_time  (rsp_query_time),
      .rsp_match_index (rsp_match_index),
      .rsp_match_time  (rsp_match_time)
   );

endmodule

`default_nettype wire

@@ test/ntm_answer_checker.sv @@
// Checker for the nearest timestamp matcher: watches the request, result and
// register ports, predicts each result and compares it field by field.
// Depends on ntm_pkg for widths and status codes.

module ntm_answer_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic                        busy,
   input  wire logic                        req_type,
   input  wire logic [ntm_pkg::TIME_W-1:0]  req_time_value,
   input  wire logic                        rsp_strobe,
   input  wire logic [ntm_pkg::STAT_W-1:0]  rsp_status,
   input  wire logic [ntm_pkg::TIME_W-1:0]  rsp_query_time,
   input  wire logic [ntm_pkg::MIDX_W-1:0]  rsp_match_index,
   input  wire logic [ntm_pkg::TIME_W-1:0]  rsp_match_time,
   input  wire logic                        csr_we,
   input  wire logic [ntm_pkg::DIFF_W-1:0]  csr_wdata,
   input  wire logic                        end_of_run,
   output int unsigned                      failures,
   output int unsigned                      awaiting
);
   timeunit 1ns;
   timeprecision 1ps;

   import ntm_pkg::*;

   // One result as the block should present it.
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [TIME_W-1:0] query_time;
      logic [MIDX_W-1:0] match_index;
      logic [TIME_W-1:0] match_time;
   } ntm_answer_type;

   // Own copy of the table, the entry count and the tolerance.
   logic [TIME_W-1:0] shadow_times [TABLE_DEPTH];
   logic [CNT_W-1:0]  stored    = '0;
   logic [DIFF_W-1:0] tolerance = MAX_DIFF_RESET;

   ntm_answer_type answers_due [$];

   initial begin
      failures = 0;
      awaiting = 0;
   end

   task automatic report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      failures = failures + 1;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
   endtask

   // Applies one request to the shadow state and works out its result.
   // A query keeps the first entry with the smallest gap, so ties go to the
   // lowest index, and a gap must be strictly below the tolerance.
   task automatic compute_answer(input logic kind, input logic [TIME_W-1:0] t,
                                 output ntm_answer_type ans);
      logic [TIME_W-1:0] best;
      logic [TIME_W-1:0] gap;
      ans.status      = ST_NOMATCH;
      ans.query_time  = t;
      ans.match_index = '0;
      ans.match_time  = '0;
      if (kind == REQ_LOAD) begin
         if (stored < DEPTH_CNT) begin
            shadow_times[stored[IDX_W-1:0]] = t;
            ans.match_index = MIDX_W'(stored);
            ans.status      = ST_LOADED;
            stored          = stored + 1'b1;
         end else begin
            ans.status = ST_FULL;
         end
      end else begin
         best = TIME_W'(tolerance);
         for (int i = 0; i < int'(stored); i++) begin
            gap = (t >= shadow_times[i]) ? t - shadow_times[i] : shadow_times[i] - t;
            if (gap < best) begin
               best            = gap;
               ans.status      = ST_MATCH;
               ans.match_index = MIDX_W'(i);
               ans.match_time  = shadow_times[i];
            end
         end
      end
   endtask

   // Everything is sampled at the rising edge; the stimulus moves on the
   // falling edge, so the values seen here are settled.
   always @(posedge clock) begin : watch
      ntm_answer_type fresh;
      ntm_answer_type oldest;
      if (reset) begin
         answers_due.delete();
         stored    = '0;
         tolerance = MAX_DIFF_RESET;
      end else begin
         if (csr_we)
            tolerance = csr_wdata;

         // A result is compared with the oldest outstanding prediction.
         if (rsp_strobe) begin
            if (answers_due.size() == 0) begin
               report($sformatf("result with status %0d and nothing outstanding",
                                rsp_status));
            end else begin
               oldest = answers_due.pop_front();
               check_field("status", 64'(rsp_status), 64'(oldest.status));
               check_field("query_time", 64'(rsp_query_time), 64'(oldest.query_time));
               check_field("match_index", 64'(rsp_match_index), 64'(oldest.match_index));
               check_field("match_time", 64'(rsp_match_time), 64'(oldest.match_time));
            end
         end

         // A request transfer adds one prediction.
         if (start && !busy) begin
            compute_answer(req_type, req_time_value, fresh);
            answers_due.insert(answers_due.size(), fresh);
         end

         if (end_of_run && answers_due.size() != 0) begin
            report($sformatf("%0d results never arrived", answers_due.size()));
            answers_due.delete();
         end
      end
      awaiting = answers_due.size();
   end

endmodule

@@ test/tb_nearest_timestamp_matcher.sv @@
// Top of the nearest timestamp matcher testbench: clock, reset, request and
// register stimulus, and the verdict. Depends on ntm_pkg, the block itself
// and ntm_answer_checker, which does all prediction and comparison.

module tb_nearest_timestamp_matcher;
   timeunit 1ns;
   timeprecision 1ps;

   import ntm_pkg::*;

   localparam int          RANDOM_ITEMS = 580;
   localparam int unsigned LIMIT_CYCLES = 6_000_000;

   logic                clock;
   logic                reset          = 1'b1;
   logic                start          = 1'b0;
   logic                req_type       = REQ_LOAD;
   logic [TIME_W-1:0]   req_time_value = '0;
   logic                csr_we         = 1'b0;
   logic [DIFF_W-1:0]   csr_wdata      = '0;
   logic                end_of_run     = 1'b0;

   logic                busy;
   logic                rsp_strobe;
   logic [STAT_W-1:0]   rsp_status;
   logic [TIME_W-1:0]   rsp_query_time;
   logic [MIDX_W-1:0]   rsp_match_index;
   logic [TIME_W-1:0]   rsp_match_time;

   int unsigned         failures;
   int unsigned         awaiting;
   int unsigned         cycle_count    = 0;
   logic                transfer_taken = 1'b0;

   // Stimulus-side knowledge, used to aim queries and loads and to pace the run.
   logic [TIME_W-1:0]   loaded [$];
   logic [DIFF_W-1:0]   tolerance_now  = MAX_DIFF_RESET;
   logic [TIME_W-1:0]   cluster_base   = '0;
   logic                steady         = 1'b0;

   nearest_timestamp_matcher uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_time_value  (req_time_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_query_time  (rsp_query_time),
      .rsp_match_index (rsp_match_index),
      .rsp_match_time  (rsp_match_time),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   ntm_answer_checker answer_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_time_value  (req_time_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_query_time  (rsp_query_time),
      .rsp_match_index (rsp_match_index),
      .rsp_match_time  (rsp_match_time),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .end_of_run      (end_of_run),
      .failures        (failures),
      .awaiting        (awaiting)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Records whether a request transfer happened at this edge.
   always @(posedge clock) begin
      transfer_taken <= !reset && start && !busy;
   end

   // Watchdog: a run that overruns the limit is a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [TIME_W-1:0] any_time();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[TIME_W-1:0];
   endfunction

   function automatic logic [TIME_W-1:0] cluster_time();
      return cluster_base + TIME_W'($urandom_range(0, 400000));
   endfunction

   // A query on, just inside or just outside the tolerance of a stored entry,
   // half way between two entries for ties, or at random within the tolerance.
   function automatic logic [TIME_W-1:0] aimed_query();
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] b;
      logic [TIME_W-1:0] span;
      logic [63:0]       w;
      if (loaded.size() == 0)
         return any_time();
      a    = loaded[$urandom_range(0, loaded.size() - 1)];
      b    = loaded[$urandom_range(0, loaded.size() - 1)];
      span = (tolerance_now == '0) ? TIME_W'(16) : TIME_W'(tolerance_now);
      w    = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: return a;
         1: return a + span;
         2: return a - span + 1'b1;
         3: return (a >> 1) + (b >> 1) + TIME_W'(a[0] & b[0]);
         default: return a + TIME_W'(w % (64'(span) * 2 + 1)) - span;
      endcase
   endfunction

   function automatic logic [DIFF_W-1:0] tolerance_pick(input int k);
      case (k)
         0: return '1;
         1: return '0;
         2: return DIFF_W'($urandom_range(1, 100000));
         3: return DIFF_W'($urandom);
         4: return DIFF_W'(1);
         default: return MAX_DIFF_RESET;
      endcase
   endfunction

   // Presents one request at the falling edge and holds it until transfer.
   // Returns at the falling edge after the transfer with start still high.
   task automatic issue(input logic kind, input logic [TIME_W-1:0] t);
      start          = 1'b1;
      req_type       = kind;
      req_time_value = t;
      do
         @(negedge clock);
      while (!transfer_taken);
      if (kind == REQ_LOAD && loaded.size() < TABLE_DEPTH)
         loaded.insert(loaded.size(), t);
   endtask

   // Mostly back to back or short gaps, now and then a long one.
   task automatic pause_random();
      int unsigned r;
      int unsigned n;
      r = $urandom_range(0, 99);
      if (r < 55)
         n = 0;
      else if (r < 85)
         n = $urandom_range(1, 3);
      else if (r < 96)
         n = $urandom_range(4, 16);
      else
         n = $urandom_range(40, 200);
      if (n != 0) begin
         start = 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Holds off further requests until every outstanding result has come.
   task automatic drain();
      start = 1'b0;
      while (awaiting != 0)
         @(negedge clock);
   endtask

   // The tolerance is only written with the block idle.
   task automatic set_tolerance(input logic [DIFF_W-1:0] value);
      drain();
      csr_we    = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we        = 1'b0;
      tolerance_now = value;
   endtask

   task automatic random_item();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < ((loaded.size() < 8) ? 70 : 40)) begin
         r = $urandom_range(0, 9);
         if (r < 6)
            issue(REQ_LOAD, cluster_time());
         else if (r < 8 && loaded.size() != 0)
            issue(REQ_LOAD, loaded[$urandom_range(0, loaded.size() - 1)]);
         else
            issue(REQ_LOAD, any_time());
      end else begin
         r = $urandom_range(0, 19);
         if (r < 13)
            issue(REQ_QUERY, aimed_query());
         else if (r < 17)
            issue(REQ_QUERY, cluster_time());
         else
            issue(REQ_QUERY, any_time());
      end
   endtask

   initial begin : stimulus
      int unsigned spare;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: queries on an empty table.
      issue(REQ_QUERY, '0);
      issue(REQ_QUERY, '1);
      pause_random();

      // Directed: extremes, a duplicate and an equal-gap tie between entries.
      issue(REQ_LOAD, '0);
      issue(REQ_LOAD, '1);
      issue(REQ_LOAD, TIME_W'(1000));
      issue(REQ_LOAD, TIME_W'(1000));
      issue(REQ_LOAD, TIME_W'(3000));
      issue(REQ_QUERY, '0);
      issue(REQ_QUERY, '1);
      issue(REQ_QUERY, TIME_W'(2000));
      issue(REQ_QUERY, TIME_W'(23000));
      issue(REQ_QUERY, TIME_W'(22999));

      // Directed: zero tolerance never matches, one matches only exact times.
      set_tolerance('0);
      issue(REQ_QUERY, TIME_W'(1000));
      set_tolerance(DIFF_W'(1));
      issue(REQ_QUERY, TIME_W'(1000));
      issue(REQ_QUERY, TIME_W'(1001));

      // Directed: widest tolerance, at its edge and far beyond it.
      set_tolerance('1);
      issue(REQ_QUERY, '1 - TIME_W'(32'hFFFF_FFFE));
      issue(REQ_QUERY, '1 - TIME_W'(32'hFFFF_FFFF));
      issue(REQ_QUERY, TIME_W'(1) << (TIME_W - 1));
      set_tolerance(MAX_DIFF_RESET);

      // Random part: entries clustered so that queries land near them.
      cluster_base = any_time() >> 1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 99)
            set_tolerance(tolerance_pick(n / 100));
         if (n % 50 == 0)
            steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 49) == 0)
            drain();
         random_item();
         if (!steady)
            pause_random();
      end

      // Fill the table, then loads that must be dropped.
      set_tolerance(MAX_DIFF_RESET);
      while (loaded.size() < TABLE_DEPTH) begin
         issue(REQ_LOAD, cluster_time());
         if ($urandom_range(0, 7) == 0)
            pause_random();
      end
      issue(REQ_LOAD, '1);
      issue(REQ_LOAD, any_time());
      pause_random();
      issue(REQ_LOAD, '0);

      // Queries over the full table, the last index among them.
      issue(REQ_QUERY, loaded[TABLE_DEPTH - 1]);
      issue(REQ_QUERY, aimed_query());
      pause_random();
      issue(REQ_QUERY, any_time());
      set_tolerance('1);
      issue(REQ_QUERY, aimed_query());
      issue(REQ_QUERY, any_time());
      set_tolerance('0);
      issue(REQ_QUERY, loaded[0]);
      set_tolerance(MAX_DIFF_RESET);
      issue(REQ_QUERY, aimed_query());

      // Wait for the last results, bounded, then a quiet stretch.
      start = 1'b0;
      spare = 2 * (TABLE_DEPTH + 4) + 64;
      while (awaiting != 0 && spare != 0) begin
         @(negedge clock);
         spare = spare - 1;
      end
      repeat (TABLE_DEPTH + 8) @(negedge clock);
      end_of_run = 1'b1;
      @(negedge clock);
      end_of_run = 1'b0;
      @(negedge clock);

      if (failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ files.f @@
design/ntm_pkg.sv
design/ntm_ctrl.sv
design/ntm_datapath.sv
design/nearest_timestamp_matcher.sv
test/ntm_answer_checker.sv
test/tb_nearest_timestamp_matcher.sv
